// ===== hw/rtl/cpu16_pkg.sv =====
package cpu16_pkg;

  localparam int ADDR_BITS = 16;

  localparam logic [15:0] CHAR_LIMIT = 16'h8000;
  localparam logic [3:0]  SEL_NONE   = 4'h8;

  localparam logic [1:0] HALT_NONE   = 2'd0;
  localparam logic [1:0] HALT_OPCODE = 2'd1;
  localparam logic [1:0] HALT_FUNCT  = 2'd2;

  localparam logic [3:0] OP_MOV  = 4'd1;
  localparam logic [3:0] OP_ALU  = 4'd2;
  localparam logic [3:0] OP_CMP  = 4'd3;
  localparam logic [3:0] OP_JLO  = 4'd4;
  localparam logic [3:0] OP_JHI  = 4'd5;
  localparam logic [3:0] OP_IACK = 4'd6;
  localparam logic [3:0] OP_VEC  = 4'd7;
  localparam logic [3:0] OP_LD   = 4'd8;
  localparam logic [3:0] OP_ST   = 4'd9;
  localparam logic [3:0] OP_CALL = 4'd10;
  localparam logic [3:0] OP_RET  = 4'd11;
  localparam logic [3:0] OP_PUSH = 4'd12;
  localparam logic [3:0] OP_POP  = 4'd13;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_AND = 3'd2;
  localparam logic [2:0] FN_OR  = 3'd3;
  localparam logic [2:0] FN_XOR = 3'd4;
  localparam logic [2:0] FN_NOT = 3'd5;
  localparam logic [2:0] FN_SHL = 3'd6;

  typedef struct packed {
    logic clear;
    logic accept;
    logic fetch;
    logic imm;
    logic exec;
    logic mem;
    logic intr;
    logic done;
  } cpu16_cmd_t;

  typedef struct packed {
    logic step;
    logic need_mem;
    logic clear_last;
  } cpu16_stat_t;

endpackage

// ===== hw/rtl/cpu16_instruction_step_core.sv =====
// Small 16-bit processor core driven one item at a time.
// Input channel (in_valid / in_stall): kind 0 writes load_word into the word
// memory at load_address; kind 1 runs one instruction step, with timer_tick
// and key_valid/key_code raising the pending bits of register 0 first.
// Output channel (out_valid / out_stall): one result per input transfer,
// giving status, any emitted character and the instruction pointer after it.
// A load goes from transfer straight to the done state, as does a step on a
// halted core. A step runs fetch, immediate, execute, interrupt and done, plus a memory
// state after execute for data reads (load, pop, return); the single-port word memory
// sets this, with fetch, immediate, data access and interrupt push each taking a turn.
// The result sits in an output register; while the receiver stalls it is
// held, and a following item may run but waits to hand over its own result.
// After reset the word memory is cleared one word per cycle, all 2^ADDR_BITS
// words (65536), during which in_stall stays high; all registers, flags,
// the vector table and the halt status start at zero.
module cpu16_instruction_step_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [15:0] load_address,
  input  logic [15:0] load_word,
  input  logic        timer_tick,
  input  logic        key_valid,
  input  logic [7:0]  key_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        char_valid,
  output logic [7:0]  char_code,
  output logic [15:0] next_ip
);
  import cpu16_pkg::*;

  cpu16_cmd_t  cmd;
  cpu16_stat_t stat;

  cpu16_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cpu16_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .load_address (load_address),
    .load_word    (load_word),
    .timer_tick   (timer_tick),
    .key_valid    (key_valid),
    .key_code     (key_code),
    .status       (status),
    .char_valid   (char_valid),
    .char_code    (char_code),
    .next_ip      (next_ip)
  );

endmodule

// ===== hw/rtl/cpu16_ctrl.sv =====
module cpu16_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  cpu16_pkg::cpu16_stat_t stat,
  output cpu16_pkg::cpu16_cmd_t  cmd
);
  import cpu16_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_FETCH = 8'b0000_0100,
    S_IMM   = 8'b0000_1000,
    S_EXEC  = 8'b0001_0000,
    S_MEM   = 8'b0010_0000,
    S_INT   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   done_fire;

  assign in_stall  = (state != S_IDLE);
  assign done_fire = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    cmd        = '0;
    cmd.clear  = (state == S_CLEAR);
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.fetch  = (state == S_FETCH);
    cmd.imm    = (state == S_IMM);
    cmd.exec   = (state == S_EXEC);
    cmd.mem    = (state == S_MEM);
    cmd.intr   = (state == S_INT);
    cmd.done   = done_fire;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (stat.clear_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) state_next = stat.step ? S_FETCH : S_DONE;
      end
      S_FETCH: state_next = S_IMM;
      S_IMM:   state_next = S_EXEC;
      S_EXEC:  state_next = stat.need_mem ? S_MEM : S_INT;
      S_MEM:   state_next = S_INT;
      S_INT:   state_next = S_DONE;
      S_DONE:  if (done_fire) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (done_fire) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_fetch_from_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |-> $past(state) == S_IDLE)
    else $error("fetch not entered from idle");

  a_int_then_done: assert property (@(posedge clk) disable iff (rst)
    state == S_INT |=> state == S_DONE)
    else $error("interrupt phase did not finish the item");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the done phase");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !cmd.accept)
    else $error("transfer accepted during memory clearing");

endmodule

// ===== hw/rtl/cpu16_dp.sv =====
module cpu16_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  cpu16_pkg::cpu16_cmd_t  cmd,
  output cpu16_pkg::cpu16_stat_t stat,
  input  logic                  kind,
  input  logic [15:0]           load_address,
  input  logic [15:0]           load_word,
  input  logic                  timer_tick,
  input  logic                  key_valid,
  input  logic [7:0]            key_code,
  output logic [1:0]            status,
  output logic                  char_valid,
  output logic [7:0]            char_code,
  output logic [15:0]           next_ip
);
  import cpu16_pkg::*;

  logic [15:0] mem [2**ADDR_BITS];
  logic [15:0] mem_q;
  logic [15:0] mem_addr16;
  logic [15:0] mem_wdata;
  logic        mem_we;
  logic [ADDR_BITS-1:0] clr_cnt;

  logic [15:0] regs [16];
  logic [15:0] vtab [8];
  logic [15:0] ip;
  logic [3:0]  flags;
  logic [7:0]  smask;
  logic [3:0]  vsel;
  logic [7:0]  key;
  logic [1:0]  halt;
  logic        cv;
  logic [7:0]  cc;

  logic [15:0] ins_q, src_q, rs_val, rd_val;

  logic [3:0]  op, rd;
  logic [2:0]  fn;
  logic [15:0] r2_dec, r2_inc;
  logic [16:0] res;
  logic [31:0] shl;
  logic [3:0]  flags_new;
  logic        taken;
  logic [7:0]  occ;
  logic [2:0]  idx;

  assign op     = ins_q[15:12];
  assign fn     = ins_q[10:8];
  assign rd     = ins_q[7:4];
  assign r2_dec = regs[2] - 16'd1;
  assign r2_inc = regs[2] + 16'd1;

  // ALU result is 17 bits; bit 16 is carry/borrow, the shifted-out bit, or 1 for NOT.
  always_comb begin
    shl = {16'b0, rd_val} << src_q[3:0];
    case (fn)
      FN_ADD:  res = {1'b0, rd_val} + {1'b0, src_q};
      FN_SUB:  res = {1'b0, rd_val} - {1'b0, src_q};
      FN_AND:  res = {1'b0, rd_val & src_q};
      FN_OR:   res = {1'b0, rd_val | src_q};
      FN_XOR:  res = {1'b0, rd_val ^ src_q};
      FN_NOT:  res = {1'b1, ~src_q};
      FN_SHL:  res = shl[16:0];
      default: res = {1'b0, rd_val >> src_q[3:0]};
    endcase
    flags_new = {res[15],
                 (rd_val[15] ^ src_q[15]) & ~(src_q[15] ^ res[15]),
                 res[16],
                 res[15:0] == 16'd0};
  end

  // Flags are held as sign, overflow, carry, zero from the top bit down.
  always_comb begin
    logic s, o, c, z;
    s = flags[3];
    o = flags[2];
    c = flags[1];
    z = flags[0];
    case ({op[0], fn})
      4'd0:    taken = 1'b1;
      4'd1:    taken = z;
      4'd2:    taken = !z;
      4'd3:    taken = (s == o);
      4'd4:    taken = z || (s != o);
      4'd5:    taken = !z && (s == o);
      4'd6:    taken = (s != o);
      4'd7:    taken = o;
      4'd8:    taken = (regs[0][7:0] == 8'd0);
      4'd9:    taken = s;
      4'd10:   taken = !s;
      4'd11:   taken = !c;
      4'd12:   taken = c || z;
      4'd13:   taken = !c || !z;
      4'd14:   taken = c;
      default: taken = !o;
    endcase
  end

  // Highest pending line has priority; line 7 of the upper byte maps to entry 0.
  always_comb begin
    occ = regs[0][15:8] & regs[1][15:8];
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (occ[i]) idx = 3'(7 - i);
    end
  end

  always_comb begin
    mem_addr16 = ip;
    mem_wdata  = 16'd0;
    mem_we     = 1'b0;
    if (cmd.clear) begin
      mem_addr16 = 16'(clr_cnt);
      mem_we     = 1'b1;
    end else if (cmd.accept) begin
      if (!kind) begin
        mem_addr16 = load_address;
        mem_wdata  = load_word;
        mem_we     = 1'b1;
      end
    end else if (cmd.fetch) begin
      mem_addr16 = ip + 16'd1;
    end else if (cmd.exec) begin
      case (op)
        OP_LD: mem_addr16 = src_q;
        OP_ST: begin
          mem_addr16 = src_q;
          mem_wdata  = rd_val;
          mem_we     = (src_q >= CHAR_LIMIT);
        end
        OP_CALL: begin
          mem_addr16 = r2_dec;
          mem_wdata  = ip;
          mem_we     = (r2_dec >= CHAR_LIMIT);
        end
        OP_PUSH: begin
          mem_addr16 = r2_dec;
          mem_wdata  = src_q;
          mem_we     = (r2_dec >= CHAR_LIMIT);
        end
        default: mem_addr16 = regs[2];
      endcase
    end else if (cmd.intr) begin
      mem_addr16 = r2_dec;
      mem_wdata  = ip;
      mem_we     = (halt == HALT_NONE) && (occ != 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr16[ADDR_BITS-1:0]] <= mem_wdata;
    mem_q <= mem[mem_addr16[ADDR_BITS-1:0]];
  end

  assign stat.step       = kind && (halt == HALT_NONE);
  assign stat.need_mem   = (op == OP_LD) || (op == OP_POP) || ((op == OP_RET) && !fn[2] && !fn[1]);
  assign stat.clear_last = &clr_cnt;

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      ins_q  <= mem_q;
      rs_val <= regs[mem_q[3:0]];
      rd_val <= regs[mem_q[7:4]];
    end
    if (cmd.imm) src_q <= ins_q[11] ? mem_q : rs_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) regs[i] <= 16'd0;
      for (int i = 0; i < 8; i++) vtab[i] <= 16'd0;
      ip         <= 16'd0;
      flags      <= 4'd0;
      smask      <= 8'd0;
      vsel       <= SEL_NONE;
      key        <= 8'd0;
      halt       <= HALT_NONE;
      cv         <= 1'b0;
      cc         <= 8'd0;
      clr_cnt    <= '0;
      status     <= HALT_NONE;
      char_valid <= 1'b0;
      char_code  <= 8'd0;
      next_ip    <= 16'd0;
    end else begin
      if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.accept) begin
        cv <= 1'b0;
        cc <= 8'd0;
        if (kind && (halt == HALT_NONE)) begin
          if (timer_tick) regs[0][15] <= 1'b1;
          if (key_valid) begin
            regs[0][14] <= 1'b1;
            key         <= key_code;
          end
        end
      end
      if (cmd.fetch) ip <= ip + 16'd1;
      if (cmd.imm && ins_q[11]) ip <= ip + 16'd1;
      // Register 0 is never written as a destination; only acknowledge clears its bits.
      if (cmd.exec) begin
        case (op)
          OP_MOV: if (rd != 4'd0) regs[rd] <= src_q;
          OP_ALU: begin
            flags <= flags_new;
            if (rd != 4'd0) regs[rd] <= res[15:0];
          end
          OP_CMP: begin
            if (fn == FN_SUB || fn == FN_AND) flags <= flags_new;
            else halt <= HALT_FUNCT;
          end
          OP_JLO, OP_JHI: if (taken) ip <= src_q;
          OP_IACK: begin
            if (fn == 3'd1 && rd != 4'd0) regs[rd] <= {{8{key[7]}}, key};
            regs[0] <= regs[0] & ~(16'h8000 >> fn);
          end
          OP_VEC: begin
            if (fn == 3'd0) begin
              if (vsel[3]) vsel <= {1'b0, src_q[2:0]};
              else begin
                vtab[vsel[2:0]] <= src_q;
                vsel            <= SEL_NONE;
              end
            end
          end
          OP_LD: ;
          OP_ST: begin
            if (src_q < CHAR_LIMIT) begin
              cv <= 1'b1;
              cc <= rd_val[7:0];
            end
          end
          OP_CALL: begin
            if (r2_dec < CHAR_LIMIT) begin
              cv <= 1'b1;
              cc <= ip[7:0];
            end
            regs[2] <= r2_dec;
            ip      <= src_q;
          end
          OP_RET: if (fn[2] || fn[1]) halt <= HALT_FUNCT;
          OP_PUSH: begin
            if (r2_dec < CHAR_LIMIT) begin
              cv <= 1'b1;
              cc <= src_q[7:0];
            end
            regs[2] <= r2_dec;
          end
          OP_POP: ;
          default: halt <= HALT_OPCODE;
        endcase
      end
      if (cmd.mem) begin
        case (op)
          OP_LD: if (rd != 4'd0) regs[rd] <= mem_q;
          OP_POP: begin
            // Popping into the stack pointer leaves it one above the popped word.
            if (rd == 4'd2) regs[2] <= mem_q + 16'd1;
            else begin
              if (rd != 4'd0) regs[rd] <= mem_q;
              regs[2] <= r2_inc;
            end
          end
          OP_RET: begin
            ip      <= mem_q;
            regs[2] <= r2_inc;
            if (fn == 3'd1) regs[1][15:8] <= smask;
          end
          default: ;
        endcase
      end
      if (cmd.intr && (halt == HALT_NONE) && (occ != 8'd0)) begin
        smask         <= regs[1][15:8];
        regs[1][15:8] <= 8'd0;
        regs[2]       <= r2_dec;
        ip            <= vtab[idx];
      end
      if (cmd.done) begin
        status     <= halt;
        char_valid <= cv;
        char_code  <= cc;
        next_ip    <= ip;
      end
    end
  end

endmodule
